FILE: hdl/tpad_pkg.sv
// Shared types and constants for the touchpad serial converter port.
// Used by tpad_core and touchpad_adc_serial_port; no dependencies.
`timescale 1ns / 1ps

package tpad_pkg;

  // Item kinds carried in s_axis_tuser.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_PAD   = 2'd3;

  // Written pin positions.
  localparam int PIN_SCK = 0;
  localparam int PIN_SI  = 1;
  localparam int PIN_CS  = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EOC_DELAY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_Y    = 1'd1;

  localparam logic [7:0] EOC_DELAY_RESET = 8'd56;
  localparam logic [7:0] IDLE_Y_RESET    = 8'd148;
  localparam logic [7:0] EOC_COUNT_MAX   = 8'hFF;

  localparam logic [1:0] CHAN_X = 2'd0;
  localparam logic [1:0] CHAN_Y = 2'd3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] write_pins;
    logic [7:0] pad_x;
    logic [7:0] pad_y;
    logic       pad_touch;
    logic       pad_button;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [7:0]             data;
  } cfg_write_t;

endpackage

FILE: hdl/touchpad_adc_serial_port.sv
// A read word passes through the input register and then the output register before
// it is valid on m_axis. One word per cycle is taken, except while a read waits for the output register.
// A read leaves the input register only while the output register is empty or being
// taken; other words never wait, so input stalls only when a read meets a held result.
// Reset (rst, synchronous, active high) empties both registers, clears the
// pad and converter state and loads the register defaults 56 and 148.
// Top level; depends on tpad_pkg and tpad_core.
`timescale 1ns / 1ps

module touchpad_adc_serial_port (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: write_pins[2:0], pad_x[7:0], pad_y[7:0], pad_touch, pad_button
  input  logic [tpad_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: read_pins[5:0], two zero bits
  output logic [tpad_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpad_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                         cfg_data
);

  tpad_pkg::item_t     in_item;
  tpad_pkg::cfg_write_t cfg;
  logic                in_valid;
  logic                proceed;
  logic                fire;
  logic                out_valid;
  logic [5:0]          out_pins;
  logic [5:0]          read_pins;

  // A read may only leave the input register when the output register frees up.
  assign proceed = (in_item.action != tpad_pkg::ACT_READ) || !out_valid || m_axis_tready;
  assign fire    = in_valid && proceed;
  assign s_axis_tready = !in_valid || proceed;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.action     <= s_axis_tuser;
      in_item.write_pins <= s_axis_tdata[2:0];
      in_item.pad_x      <= s_axis_tdata[10:3];
      in_item.pad_y      <= s_axis_tdata[18:11];
      in_item.pad_touch  <= s_axis_tdata[19];
      in_item.pad_button <= s_axis_tdata[20];
    end
  end

  tpad_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .item      (in_item),
    .read_pins (read_pins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.action == tpad_pkg::ACT_READ) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.action == tpad_pkg::ACT_READ) begin
      out_pins <= read_pins;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_pins};

`ifndef SYNTHESIS
  a_read_blocks_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.action == tpad_pkg::ACT_READ && out_valid && !m_axis_tready)
      |-> !s_axis_tready)
    else $error("read word left the input register while the output was full");

  a_no_result_from_other: assert property (@(posedge clk) disable iff (rst)
    (fire && in_item.action != tpad_pkg::ACT_READ && !out_valid) |=> !out_valid)
    else $error("result produced for a word that is not a read");

  a_fixed_ones: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:4] == 2'b11))
    else $error("read result lost its fixed high bits");
`endif

endmodule

FILE: hdl/tpad_core.sv
// Converter and pad state: pin edge handling, shift register, end-of-conversion
// counter, pad sample and read-back value. Depends on tpad_pkg.
`timescale 1ns / 1ps

module tpad_core (
  input  logic                clk,
  input  logic                rst,
  input  tpad_pkg::cfg_write_t cfg,
  input  logic                fire,
  input  tpad_pkg::item_t     item,
  output logic [5:0]          read_pins
);

  logic [7:0] eoc_delay;
  logic [7:0] idle_y;
  logic [2:0] last_pins;
  logic [7:0] shift_reg;
  logic [1:0] sel_channel;
  logic [7:0] eoc_count;
  logic [7:0] cur_x;
  logic [7:0] cur_y;
  logic       cur_touch;
  logic       cur_button;

  logic [7:0] shift_reg_next;
  logic [7:0] sample;
  logic [2:0] diff;

  always_comb begin
    unique case (sel_channel)
      tpad_pkg::CHAN_X: sample = cur_touch ? cur_x : 8'd0;
      tpad_pkg::CHAN_Y: sample = cur_touch ? cur_y : idle_y;
      default:          sample = 8'd0;
    endcase
  end

  assign diff = last_pins ^ item.write_pins;

  // The select edge is taken before the clock edge of the same write.
  always_comb begin
    shift_reg_next = shift_reg;
    if (diff[tpad_pkg::PIN_CS] && !item.write_pins[tpad_pkg::PIN_CS]) begin
      shift_reg_next = sample;
    end
    if (!item.write_pins[tpad_pkg::PIN_CS] && item.write_pins[tpad_pkg::PIN_SCK] &&
        diff[tpad_pkg::PIN_SCK]) begin
      shift_reg_next = {shift_reg_next[6:0], item.write_pins[tpad_pkg::PIN_SI]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eoc_delay   <= tpad_pkg::EOC_DELAY_RESET;
      idle_y      <= tpad_pkg::IDLE_Y_RESET;
      last_pins   <= 3'd0;
      shift_reg   <= 8'd0;
      sel_channel <= 2'd0;
      eoc_count   <= 8'd0;
      cur_x       <= 8'd0;
      cur_y       <= 8'd0;
      cur_touch   <= 1'b0;
      cur_button  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          tpad_pkg::CFG_EOC_DELAY: eoc_delay <= cfg.data;
          tpad_pkg::CFG_IDLE_Y:    idle_y    <= cfg.data;
          default: ;
        endcase
      end
      if (fire) begin
        unique case (item.action)
          tpad_pkg::ACT_WRITE: begin
            last_pins <= item.write_pins;
            shift_reg <= shift_reg_next;
            if (diff[tpad_pkg::PIN_CS] && item.write_pins[tpad_pkg::PIN_CS]) begin
              sel_channel <= shift_reg[1:0];
              eoc_count   <= 8'd0;
            end
          end
          tpad_pkg::ACT_TICK: begin
            if (eoc_count != tpad_pkg::EOC_COUNT_MAX) begin
              eoc_count <= eoc_count + 8'd1;
            end
          end
          tpad_pkg::ACT_PAD: begin
            cur_x      <= item.pad_x;
            cur_y      <= item.pad_y;
            cur_touch  <= item.pad_touch;
            cur_button <= item.pad_button;
          end
          default: ;
        endcase
      end
    end
  end

  assign read_pins = {2'b11, ~cur_button,
                      shift_reg[7] | last_pins[tpad_pkg::PIN_CS],
                      eoc_count > eoc_delay, ~cur_touch};

endmodule
